// ===== src/tsd_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the scratchpad decoder.
// No dependencies; used by tsd_ctrl, tsd_datapath and the top level.
package tsd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned TempW     = 16;
  localparam int unsigned StoreDepth = 8;
  localparam int unsigned PosW      = $clog2(StoreDepth);

  localparam logic [PosW-1:0]  PosFirst    = '0;
  localparam logic [PosW-1:0]  PosLast     = PosW'(StoreDepth - 1);
  localparam logic [ByteW-1:0] CrcPoly     = 8'h8C;
  localparam logic [ByteW-1:0] CountPerC   = 8'h10;
  localparam logic [TempW-1:0] HalfDegMask = 16'hFFF0;
  localparam logic [TempW-1:0] CountBias   = 16'd12;

  // Scratchpad byte indexes the decoder reads.
  localparam logic [PosW-1:0] IdxTempLsb = 3'd0;
  localparam logic [PosW-1:0] IdxTempMsb = 3'd1;
  localparam logic [PosW-1:0] IdxConfig  = 3'd4;
  localparam logic [PosW-1:0] IdxRemain  = 3'd6;
  localparam logic [PosW-1:0] IdxPerC    = 3'd7;

  // Resolution codes in bits 6..5 of the configuration byte.
  localparam logic [1:0] Res9Bit  = 2'b00;
  localparam logic [1:0] Res10Bit = 2'b01;
  localparam logic [1:0] Res11Bit = 2'b10;

  typedef enum logic {
    ST_BODY,
    ST_CRC
  } state_e;

  typedef struct packed {
    logic            wr_en;
    logic [PosW-1:0] wr_idx;
    logic            crc_restart;
    logic            finish;
  } cmd_t;

  // One byte of the reflected CRC-8, LSB first.
  function automatic logic [ByteW-1:0] crc_update(input logic [ByteW-1:0] crc_in,
                                                  input logic [ByteW-1:0] data_in);
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] b;
    logic             mix;
    crc = crc_in;
    b   = data_in;
    for (int i = 0; i < ByteW; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

// ===== src/tsd_ctrl.sv =====
// Frame controller: tracks the byte position and the output register's valid.
// Depends on tsd_pkg; drives commands into tsd_datapath.
module tsd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_start_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tsd_pkg::cmd_t cmd_o
);

  tsd_pkg::state_e           state_q, state_d;
  logic [tsd_pkg::PosW-1:0]  pos_q, pos_d;
  logic                      out_valid_q, out_valid_d;
  logic                      accept;

  assign accept = in_valid_i & in_ready_o;

  // Next state and position.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    if (accept) begin
      if (in_start_i) begin
        state_d = tsd_pkg::ST_BODY;
        pos_d   = tsd_pkg::PosFirst + 1'b1;
      end else begin
        case (state_q)
          tsd_pkg::ST_BODY: begin
            pos_d   = pos_q + 1'b1;
            state_d = (pos_q == tsd_pkg::PosLast) ? tsd_pkg::ST_CRC : tsd_pkg::ST_BODY;
          end
          tsd_pkg::ST_CRC: begin
            pos_d   = tsd_pkg::PosFirst;
            state_d = tsd_pkg::ST_BODY;
          end
          default: begin
            pos_d   = tsd_pkg::PosFirst;
            state_d = tsd_pkg::ST_BODY;
          end
        endcase
      end
    end
  end

  // Outputs and commands.
  always_comb begin
    // Stall any byte in the CRC slot while an untaken result is pending.
    in_ready_o = !((state_q == tsd_pkg::ST_CRC) && out_valid_q && !out_ready_i);
    cmd_o.wr_en       = accept && (in_start_i || (state_q == tsd_pkg::ST_BODY));
    cmd_o.wr_idx      = in_start_i ? tsd_pkg::PosFirst : pos_q;
    cmd_o.crc_restart = in_start_i;
    cmd_o.finish      = accept && !in_start_i && (state_q == tsd_pkg::ST_CRC);
    out_valid_d = cmd_o.finish | (out_valid_q & ~out_ready_i);
    out_valid_o = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsd_pkg::ST_BODY;
      pos_q       <= tsd_pkg::PosFirst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/tsd_datapath.sv =====
// Datapath: running CRC, scratchpad store, raw decode and held temperature.
// Depends on tsd_pkg; steered by tsd_ctrl commands.
module tsd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsd_pkg::cmd_t               cmd_i,
  input  logic [tsd_pkg::ByteW-1:0]   data_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_type_i,
  output logic [tsd_pkg::TempW-1:0]   temp_o,
  output logic                        crc_ok_o
);

  logic [tsd_pkg::ByteW-1:0] store_q [tsd_pkg::StoreDepth];
  logic [tsd_pkg::ByteW-1:0] crc_q, crc_d;
  logic [tsd_pkg::TempW-1:0] temp_q, temp_d;
  logic                      crc_ok_q;
  logic                      dev_type_q;
  logic                      match;
  logic [tsd_pkg::TempW-1:0] raw, shifted, decoded;

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.finish) begin
      crc_d = '0;
    end else if (cmd_i.wr_en) begin
      crc_d = tsd_pkg::crc_update(cmd_i.crc_restart ? '0 : crc_q, data_i);
    end
  end

  assign match = (crc_q == data_i);

  always_comb begin
    raw     = {store_q[tsd_pkg::IdxTempMsb], store_q[tsd_pkg::IdxTempLsb]};
    shifted = raw << 3;
    decoded = raw;
    if (dev_type_q) begin
      decoded = shifted;
      if (store_q[tsd_pkg::IdxPerC] == tsd_pkg::CountPerC) begin
        decoded = (shifted & tsd_pkg::HalfDegMask) + tsd_pkg::CountBias
                  - {8'h00, store_q[tsd_pkg::IdxRemain]};
      end
    end else begin
      case (store_q[tsd_pkg::IdxConfig][6:5])
        tsd_pkg::Res9Bit:  decoded = raw & 16'hFFF8;
        tsd_pkg::Res10Bit: decoded = raw & 16'hFFFC;
        tsd_pkg::Res11Bit: decoded = raw & 16'hFFFE;
        default:           decoded = raw;
      endcase
    end
    temp_d = (cmd_i.finish && match) ? decoded : temp_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[cmd_i.wr_idx] <= data_i;
    end
    if (cmd_i.finish) begin
      crc_ok_q <= match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      temp_q     <= '0;
      dev_type_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      temp_q <= temp_d;
      if (cfg_we_i) begin
        dev_type_q <= cfg_type_i;
      end
    end
  end

  assign temp_o   = temp_q;
  assign crc_ok_o = crc_ok_q;

endmodule

// ===== src/ds18x20_scratchpad_decode_unit.sv =====
// Top level of the 1-Wire thermometer scratchpad decoder.
// Depends on tsd_pkg, tsd_ctrl and tsd_datapath.
//   The input stream carries one scratchpad byte per transfer, bytes 0 to 8
//   in order. tuser high marks byte 0 and restarts the count and the CRC; a
//   frame cut short by a new start is dropped without a result. After
//   reset, and after every byte 8, the next byte counts as byte 0.
//   Bytes 0..7 feed the CRC-8 and the scratchpad store. Byte 8 is compared
//   with the CRC; its transfer produces one result transfer carrying the
//   held temperature in 1/16 degC (updated only on a CRC match) and the
//   match flag.
//   Throughput: one byte per cycle unless stalled. Latency: the result is
//   valid in the cycle after the byte 8 transfer; decode and CRC check sit
//   in one combinational stage ahead of the output register.
//   Stall: the result holds in the output register while the receiver is
//   not ready. Bytes 0..7 keep flowing; the byte that follows byte 7 (the
//   CRC byte, or a new start in its place) waits until the result is taken.
//   Configuration: the one-bit device type is written through the cfg
//   channel, always ready; write it only while the block is idle.
//   Reset: position, CRC, device type and held temperature clear to zero;
//   no result is pending. The store needs no clearing.
module ds18x20_scratchpad_decode_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] temperature_sixteenths (signed)
  output logic        m_axis_tuser_o,   // [0] crc_ok
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i        // [0] device_type
);

  tsd_pkg::cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  tsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_start_i  (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  tsd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .data_i     (s_axis_tdata_i),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_type_i (cfg_data_i),
    .temp_o     (m_axis_tdata_o),
    .crc_ok_o   (m_axis_tuser_o)
  );

`ifndef ASSERT_OFF
  // A completed frame always presents a result in the next cycle.
  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("frame finished without a result");

  // Never finish a frame over a result the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !cmd.finish)
    else $error("pending result overwritten");

  // The held temperature changes only on a finishing transfer.
  a_temp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.finish |=> $stable(m_axis_tdata_o))
    else $error("temperature changed outside a frame end");
`endif

endmodule
